/* hdl/ktn_pkg.sv */
// shared types, constants and control program of the k-ary tree neighbour block
`timescale 1ns / 1ps

package ktn_pkg;

    localparam int MAX_FANOUT = 32;
    localparam int MAX_NODES  = 4096;

    localparam int RANK_W  = 12;
    localparam int SIZE_W  = 13;
    localparam int FAN_W   = 6;
    localparam int SLOT_W  = 5;
    localparam int ACC_W   = 24;
    localparam int STEP_W  = 4;

    localparam int DATA_IN_W  = 24;
    localparam int DATA_OUT_W = 24;
    localparam int USER_OUT_W = 2;

    localparam logic REG_NODE_COUNT = 1'b0;
    localparam logic REG_FANOUT     = 1'b1;

    typedef logic [STEP_W-1:0] step_t;

    localparam step_t STEP_IDLE       = 4'd0;
    localparam step_t STEP_CHK_BAD    = 4'd1;
    localparam step_t STEP_CHK_SMALL  = 4'd2;
    localparam step_t STEP_LEVEL      = 4'd3;
    localparam step_t STEP_PREP       = 4'd4;
    localparam step_t STEP_COUNT      = 4'd5;
    localparam step_t STEP_PARENT     = 4'd6;
    localparam step_t STEP_EMIT_PAR   = 4'd7;
    localparam step_t STEP_KID_CHK    = 4'd8;
    localparam step_t STEP_EMIT_KID   = 4'd9;
    localparam step_t STEP_EMIT_BAD   = 4'd10;
    localparam step_t STEP_EMIT_SMALL = 4'd11;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_LEVEL,
        OP_PREP,
        OP_COUNT,
        OP_PSUB,
        OP_EMIT_PAR,
        OP_EMIT_KID,
        OP_EMIT_BAD,
        OP_EMIT_SMALL
    } dp_op_t;

    typedef enum logic [3:0] {
        COND_ALWAYS,
        COND_IN_VALID,
        COND_BAD,
        COND_SMALL,
        COND_LEVEL,
        COND_CHILD,
        COND_PSTEP,
        COND_MORE,
        COND_OUT_FREE
    } cond_t;

    typedef struct packed {
        cond_t  cond;
        dp_op_t op;
        step_t  t_true;
        step_t  t_false;
    } ucode_t;

    typedef struct packed {
        dp_op_t op;
        logic   fire;
    } dp_ctl_t;

    typedef struct packed {
        logic bad;
        logic small_tree;
        logic level_more;
        logic child_ok;
        logic par_step;
        logic more_kids;
    } dp_stat_t;

    typedef struct packed {
        logic               kind;
        logic [SIZE_W-1:0]  neighbour;
        logic [SLOT_W-1:0]  slot;
        logic [FAN_W-1:0]   child_count;
        logic               bad;
        logic               last;
    } result_t;

    // control program: on a true condition run op and go to t_true, else go to t_false
    function automatic ucode_t ucode_rom(input step_t pc);
        ucode_t w;
        begin
            case (pc)
                STEP_IDLE:       w = '{COND_IN_VALID, OP_LOAD,       STEP_CHK_BAD,   STEP_IDLE};
                STEP_CHK_BAD:    w = '{COND_BAD,      OP_NOP,        STEP_EMIT_BAD,  STEP_CHK_SMALL};
                STEP_CHK_SMALL:  w = '{COND_SMALL,    OP_NOP,        STEP_EMIT_SMALL, STEP_LEVEL};
                STEP_LEVEL:      w = '{COND_LEVEL,    OP_LEVEL,      STEP_LEVEL,     STEP_PREP};
                STEP_PREP:       w = '{COND_ALWAYS,   OP_PREP,       STEP_COUNT,     STEP_COUNT};
                STEP_COUNT:      w = '{COND_CHILD,    OP_COUNT,      STEP_COUNT,     STEP_PARENT};
                STEP_PARENT:     w = '{COND_PSTEP,    OP_PSUB,       STEP_PARENT,    STEP_EMIT_PAR};
                STEP_EMIT_PAR:   w = '{COND_OUT_FREE, OP_EMIT_PAR,   STEP_KID_CHK,   STEP_EMIT_PAR};
                STEP_KID_CHK:    w = '{COND_MORE,     OP_NOP,        STEP_EMIT_KID,  STEP_IDLE};
                STEP_EMIT_KID:   w = '{COND_OUT_FREE, OP_EMIT_KID,   STEP_KID_CHK,   STEP_EMIT_KID};
                STEP_EMIT_BAD:   w = '{COND_OUT_FREE, OP_EMIT_BAD,   STEP_IDLE,      STEP_EMIT_BAD};
                STEP_EMIT_SMALL: w = '{COND_OUT_FREE, OP_EMIT_SMALL, STEP_IDLE,      STEP_EMIT_SMALL};
                default:         w = '{COND_ALWAYS,   OP_NOP,        STEP_IDLE,      STEP_IDLE};
            endcase
            return w;
        end
    endfunction

endpackage

/* hdl/ktn_datapath.sv */
// datapath of the neighbour generator: level search, child count, parent walk, result forming
`timescale 1ns / 1ps

module ktn_datapath
    import ktn_pkg::*;
(
    input  logic              clk,
    input  dp_ctl_t           ctl,
    input  logic [RANK_W-1:0] in_rank,
    input  logic [RANK_W-1:0] in_root,
    input  logic [SIZE_W-1:0] node_count,
    input  logic [FAN_W-1:0]  fanout,
    output dp_stat_t          stat,
    output result_t           res
);

    logic [RANK_W-1:0] rank_reg, rank_next;
    logic [RANK_W-1:0] root_reg, root_next;
    logic [SIZE_W-1:0] size_reg, size_next;
    logic [FAN_W-1:0]  k_reg, k_next;
    logic [RANK_W-1:0] s_reg, s_next;
    logic [ACC_W-1:0]  num_reg, num_next;
    logic [ACC_W-1:0]  pow_reg, pow_next;
    logic [ACC_W-1:0]  delta_reg, delta_next;
    logic [ACC_W-1:0]  pstep_reg, pstep_next;
    logic [ACC_W-1:0]  c_reg, c_next;
    logic [RANK_W-1:0] sparent_reg, sparent_next;
    logic [RANK_W-1:0] slimit_reg, slimit_next;
    logic [FAN_W-1:0]  n_reg, n_next;
    logic [FAN_W-1:0]  i_reg, i_next;

    logic [SIZE_W-1:0] size_sat;
    logic [FAN_W-1:0]  k_sat;
    logic [SIZE_W-1:0] s_wide;
    logic [ACC_W+FAN_W-1:0] pow_prod;
    logic [ACC_W-1:0]  slimit_wide;
    logic [SIZE_W-1:0] par_sum;
    logic [SIZE_W-1:0] par_mod;
    logic [SIZE_W-1:0] kid_sum;
    logic [SIZE_W-1:0] kid_mod;

    // saturate configuration
    always_comb
    begin
        if (node_count > SIZE_W'(MAX_NODES))
            size_sat = SIZE_W'(MAX_NODES);
        else
            size_sat = node_count;
        if (fanout == '0)
            k_sat = FAN_W'(1);
        else if (fanout > FAN_W'(MAX_FANOUT))
            k_sat = FAN_W'(MAX_FANOUT);
        else
            k_sat = fanout;
    end

    // rank shifted by the root, modulo the tree size
    always_comb
    begin
        if (in_rank >= in_root)
            s_wide = {1'b0, in_rank} - {1'b0, in_root};
        else
            s_wide = {1'b0, in_rank} + size_sat - {1'b0, in_root};
    end

    assign pow_prod    = {{FAN_W{1'b0}}, pow_reg} * {{ACC_W{1'b0}}, k_reg};
    assign slimit_wide = num_reg - delta_reg;

    assign par_sum = {1'b0, sparent_reg} + {1'b0, root_reg};
    assign par_mod = (par_sum >= size_reg) ? par_sum - size_reg : par_sum;
    assign kid_sum = {1'b0, c_reg[RANK_W-1:0]} + {1'b0, root_reg};
    assign kid_mod = (kid_sum >= size_reg) ? kid_sum - size_reg : kid_sum;

    always_comb
    begin
        stat.bad        = ({1'b0, rank_reg} >= size_reg) || ({1'b0, root_reg} >= size_reg);
        stat.small_tree = size_reg < SIZE_W'(2);
        stat.level_more = num_reg <= ACC_W'(s_reg);
        stat.child_ok   = (n_reg < k_reg) && (c_reg < ACC_W'(size_reg));
        stat.par_step   = (sparent_reg >= slimit_reg) && (ACC_W'(sparent_reg) >= pstep_reg);
        stat.more_kids  = i_reg < n_reg;
    end

    always_comb
    begin
        res.kind        = 1'b0;
        res.neighbour   = '1;
        res.slot        = '0;
        res.child_count = '0;
        res.bad         = 1'b0;
        res.last        = 1'b1;
        case (ctl.op)
            OP_EMIT_PAR:
            begin
                res.neighbour   = par_mod;
                res.child_count = n_reg;
                res.last        = (n_reg == '0);
            end
            OP_EMIT_KID:
            begin
                res.kind        = 1'b1;
                res.neighbour   = kid_mod;
                res.slot        = i_reg[SLOT_W-1:0];
                res.child_count = n_reg;
                res.last        = (i_reg + FAN_W'(1)) == n_reg;
            end
            OP_EMIT_BAD:
            begin
                res.bad = 1'b1;
            end
            default:
            begin
                res.last = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        rank_next    = rank_reg;
        root_next    = root_reg;
        size_next    = size_reg;
        k_next       = k_reg;
        s_next       = s_reg;
        num_next     = num_reg;
        pow_next     = pow_reg;
        delta_next   = delta_reg;
        pstep_next   = pstep_reg;
        c_next       = c_reg;
        sparent_next = sparent_reg;
        slimit_next  = slimit_reg;
        n_next       = n_reg;
        i_next       = i_reg;
        if (ctl.fire)
        begin
            case (ctl.op)
                OP_LOAD:
                begin
                    rank_next  = in_rank;
                    root_next  = in_root;
                    size_next  = size_sat;
                    k_next     = k_sat;
                    s_next     = s_wide[RANK_W-1:0];
                    num_next   = '0;
                    pow_next   = ACC_W'(1);
                    delta_next = ACC_W'(1);
                    pstep_next = ACC_W'(1);
                end
                OP_LEVEL:
                begin
                    num_next   = num_reg + pow_reg;
                    pstep_next = delta_reg;
                    delta_next = pow_reg;
                    pow_next   = pow_prod[ACC_W-1:0];
                end
                OP_PREP:
                begin
                    sparent_next = s_reg;
                    slimit_next  = slimit_wide[RANK_W-1:0];
                    c_next       = ACC_W'(s_reg) + delta_reg;
                    n_next       = '0;
                end
                OP_COUNT:
                begin
                    n_next = n_reg + FAN_W'(1);
                    c_next = c_reg + delta_reg;
                end
                OP_PSUB:
                begin
                    sparent_next = sparent_reg - pstep_reg[RANK_W-1:0];
                end
                OP_EMIT_PAR:
                begin
                    c_next = ACC_W'(s_reg) + delta_reg;
                    i_next = '0;
                end
                OP_EMIT_KID:
                begin
                    c_next = c_reg + delta_reg;
                    i_next = i_reg + FAN_W'(1);
                end
                default:
                begin
                    n_next = n_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        rank_reg    <= rank_next;
        root_reg    <= root_next;
        size_reg    <= size_next;
        k_reg       <= k_next;
        s_reg       <= s_next;
        num_reg     <= num_next;
        pow_reg     <= pow_next;
        delta_reg   <= delta_next;
        pstep_reg   <= pstep_next;
        c_reg       <= c_next;
        sparent_reg <= sparent_next;
        slimit_reg  <= slimit_next;
        n_reg       <= n_next;
        i_reg       <= i_next;
    end

endmodule

/* hdl/kary_tree_neighbors.sv */
// top level: config registers, microcoded sequencer and output register of the neighbour generator
//
// usage: each input transaction carries a node rank and a root rank; the block answers with a
// run of output transactions: the parent first, then every child in order, tlast on the final one
// a node or root rank not below the node count gives a single transaction flagged bad in tuser
// config: node_count (index 0) and fanout (index 1) are written through cfg_we/cfg_index/cfg_data
// by the user only while the block is idle, which the block does not enforce;
// reset loads node_count 1 and fanout 2
// sequence: load and checks of the rank and tree size, level search, setup, child count,
// parent walk, then the parent, each child with a check before it, and one closing check
// throughput: one input transaction at a time; the step counter of the control program sets the
// pace; the last output waits in the output register while the next input is taken
// stall: when m_axis_tready is low a full output register holds and the program waits at its emit step
// reset: the step counter returns to idle and the output register empties
`timescale 1ns / 1ps

module kary_tree_neighbors
    import ktn_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic                  cfg_index,
    input  logic [SIZE_W-1:0]     cfg_data,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [DATA_IN_W-1:0]  s_axis_tdata,   // node_rank, root_rank
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [DATA_OUT_W-1:0] m_axis_tdata,   // neighbour, slot, child_count
    output logic [USER_OUT_W-1:0] m_axis_tuser,   // kind, bad
    output logic                  m_axis_tlast
);

    logic [SIZE_W-1:0] node_count_reg, node_count_next;
    logic [FAN_W-1:0]  fanout_reg, fanout_next;
    step_t             pc_reg, pc_next;

    logic                  out_valid_reg, out_valid_next;
    logic [DATA_OUT_W-1:0] out_data_reg, out_data_next;
    logic [USER_OUT_W-1:0] out_user_reg, out_user_next;
    logic                  out_last_reg, out_last_next;

    ucode_t   word;
    logic     cond_hit;
    logic     out_free;
    logic     emit;
    dp_ctl_t  ctl;
    dp_stat_t stat;
    result_t  res;

    ktn_datapath u_dp (
        .clk        (clk),
        .ctl        (ctl),
        .in_rank    (s_axis_tdata[RANK_W-1:0]),
        .in_root    (s_axis_tdata[2*RANK_W-1:RANK_W]),
        .node_count (node_count_reg),
        .fanout     (fanout_reg),
        .stat       (stat),
        .res        (res)
    );

    // config writes
    always_comb
    begin
        node_count_next = node_count_reg;
        fanout_next     = fanout_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_NODE_COUNT: node_count_next = cfg_data;
                REG_FANOUT:     fanout_next     = cfg_data[FAN_W-1:0];
                default:        node_count_next = node_count_reg;
            endcase
        end
    end

    assign word     = ucode_rom(pc_reg);
    assign out_free = !out_valid_reg || m_axis_tready;

    // condition select
    always_comb
    begin
        case (word.cond)
            COND_ALWAYS:   cond_hit = 1'b1;
            COND_IN_VALID: cond_hit = s_axis_tvalid;
            COND_BAD:      cond_hit = stat.bad;
            COND_SMALL:    cond_hit = stat.small_tree;
            COND_LEVEL:    cond_hit = stat.level_more;
            COND_CHILD:    cond_hit = stat.child_ok;
            COND_PSTEP:    cond_hit = stat.par_step;
            COND_MORE:     cond_hit = stat.more_kids;
            COND_OUT_FREE: cond_hit = out_free;
            default:       cond_hit = 1'b0;
        endcase
    end

    // next step
    always_comb
    begin
        if (cond_hit)
            pc_next = word.t_true;
        else
            pc_next = word.t_false;
    end

    // control outputs
    always_comb
    begin
        ctl.op        = word.op;
        ctl.fire      = cond_hit;
        s_axis_tready = (pc_reg == STEP_IDLE);
        emit          = cond_hit && (word.op inside {OP_EMIT_PAR, OP_EMIT_KID,
                                                     OP_EMIT_BAD, OP_EMIT_SMALL});
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_user_next  = out_user_reg;
        out_last_next  = out_last_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            out_data_next  = {res.child_count, res.slot, res.neighbour};
            out_user_next  = {res.bad, res.kind};
            out_last_next  = res.last;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;
    assign m_axis_tlast  = out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= SIZE_W'(1);
            fanout_reg     <= FAN_W'(2);
            pc_reg         <= STEP_IDLE;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            node_count_reg <= node_count_next;
            fanout_reg     <= fanout_next;
            pc_reg         <= pc_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        out_user_reg <= out_user_next;
        out_last_reg <= out_last_next;
    end

endmodule
